>>> rtl/core/bist_pkg.sv
// ----------------------------------------------------------------------------
// bist_pkg
// Shared types and constants for the bounded integer set table.
// ----------------------------------------------------------------------------
package bist_pkg;

	// default number of entries in the table
	localparam int unsigned CAPACITY_DEF = 128;

	// widths of the request and result items
	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned ACTION_W  = 2;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned COUNT_W   = 8;
	localparam int unsigned S_TDATA_W = 40;
	localparam int unsigned M_TDATA_W = 16;

	// request actions; the unused code acts as a lookup
	typedef enum logic [ACTION_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_LOOKUP = 2'd2,
		ACT_SPARE  = 2'd3
	} action_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STS_DONE   = 2'd0,
		STS_DUP    = 2'd1,
		STS_FULL   = 2'd2,
		STS_ABSENT = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MOVE_RD,
		ST_MOVE_WR,
		ST_FINISH
	} state_t;

endpackage

>>> rtl/core/bist_ram.sv
// ----------------------------------------------------------------------------
// bist_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bist_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 128,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/bounded_integer_set_table.sv
// Flow: a request scans the stored entries in order; a remove that hits then
//   reads the last entry, which is written into the freed slot in ST_FINISH.
// Requests are taken one at a time, a new one only once the last result is
//   registered; the entry scan runs through the single RAM read port.
// Reset: arst_n clears the count and the handshakes; RAM contents are not
//   cleared, only entries below the count are ever read.
// ----------------------------------------------------------------------------
// bounded_integer_set_table
// Set of distinct 32-bit integers with fixed capacity: insert, remove and
// lookup by a sequential scan of the stored entries.
// ----------------------------------------------------------------------------
module bounded_integer_set_table #(
	parameter int unsigned CAPACITY = bist_pkg::CAPACITY_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// request: [1:0] action, [33:2] value, [39:34] zero
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [bist_pkg::S_TDATA_W-1:0] s_tdata,
	// result: [0] found, [2:1] status, [10:3] count, [11] empty_res, [15:12] zero
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [bist_pkg::M_TDATA_W-1:0] m_tdata
);

	import bist_pkg::*;

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	state_t state_q, state_d;

	action_t             action_q;
	logic [VALUE_W-1:0]  value_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       idx_q;
	logic                cmp_vld_s1;
	logic [AW-1:0]       cmp_idx_s1;
	logic                found_q;
	logic [AW-1:0]       slot_q;
	logic [VALUE_W-1:0]  last_q;
	logic                m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [VALUE_W-1:0]  ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [VALUE_W-1:0]  ram_rdata;

	logic                accept;
	logic                issue;
	logic                hit;
	logic                scan_end;
	logic                out_free;
	logic [CW-1:0]       cnt_dec;
	logic [CW-1:0]       cnt_d;
	status_t             status_d;
	logic [CW+7:0]       cnt_ext;

	bist_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// scan compare and handshake terms
	assign accept   = s_tvalid && s_tready;
	assign hit      = cmp_vld_s1 && (ram_rdata == value_q);
	assign scan_end = !cmp_vld_s1 && !(idx_q < cnt_q);
	assign issue    = (state_q == ST_SCAN) && (idx_q < cnt_q) && !hit;
	assign out_free = !m_tvalid_q || m_tready;
	assign cnt_dec  = cnt_q - 1'b1;
	assign cnt_ext  = {8'd0, cnt_d};

	// sequencer next state, RAM control and result decision
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = cnt_q[AW-1:0];
		ram_wdata = value_q;
		ram_raddr = idx_q[AW-1:0];
		cnt_d     = cnt_q;
		status_d  = STS_DONE;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					state_d = (action_q == ACT_REMOVE) ? ST_MOVE_RD : ST_FINISH;
				end else if (scan_end) begin
					state_d = ST_FINISH;
				end
			end
			ST_MOVE_RD: begin
				ram_raddr = cnt_dec[AW-1:0];
				state_d   = ST_MOVE_WR;
			end
			ST_MOVE_WR: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				unique case (action_q)
					ACT_INSERT: begin
						if (cnt_q >= CW'(CAPACITY)) begin
							status_d = STS_FULL;
						end else if (found_q) begin
							status_d = STS_DUP;
						end else begin
							ram_we = out_free;
							cnt_d  = cnt_q + 1'b1;
						end
					end
					ACT_REMOVE: begin
						if (found_q) begin
							ram_we    = out_free;
							ram_waddr = slot_q;
							ram_wdata = last_q;
							cnt_d     = cnt_dec;
						end else begin
							status_d = STS_ABSENT;
						end
					end
					ACT_LOOKUP, ACT_SPARE: begin
						status_d = found_q ? STS_DONE : STS_ABSENT;
					end
				endcase
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state, count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= issue;
			if ((state_q == ST_FINISH) && out_free) begin
				cnt_q      <= cnt_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// request capture, scan pointer and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action_t'(s_tdata[ACTION_W-1:0]);
			value_q  <= s_tdata[ACTION_W +: VALUE_W];
			idx_q    <= '0;
			found_q  <= 1'b0;
		end
		if (issue) begin
			idx_q <= idx_q + 1'b1;
		end
		cmp_idx_s1 <= idx_q[AW-1:0];
		if ((state_q == ST_SCAN) && hit) begin
			found_q <= 1'b1;
			slot_q  <= cmp_idx_s1;
		end
		if (state_q == ST_MOVE_WR) begin
			last_q <= ram_rdata;
		end
		if ((state_q == ST_FINISH) && out_free) begin
			m_tdata_q <= {4'd0, (cnt_d == '0), cnt_ext[7:0], status_d, found_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> tb/tb_bounded_integer_set_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_integer_set_table
// Self-checking bench for the bounded integer set table. A shadow copy of the
// table predicts found, status, count and empty for every accepted request.
// Directed requests cover the empty table, the value extremes and every
// action. Random phases then fill the table, drain it and mix the actions,
// with idle cycles on either side and one long stall on the result side.
// ----------------------------------------------------------------------------
module tb_bounded_integer_set_table;
	import bist_pkg::*;

	localparam int unsigned CAP      = CAPACITY_DEF;
	localparam int          POOL_N   = 256;
	localparam int          HOLD_LEN = 400;
	localparam int          WD_LIMIT = 5000;
	localparam int          TAIL_CYC = CAP + 40;

	// one request as packed into s_tdata
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		action_t            act;
	} set_request_t;

	// one result as packed into m_tdata[11:0]
	typedef struct packed {
		logic               empty_res;
		logic [COUNT_W-1:0] count;
		status_t            status;
		logic               found;
	} set_outcome_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	set_request_t  request_q[$];
	set_outcome_t  outcome_q[$];
	logic [31:0]   set_members[CAP];
	int unsigned   member_cnt;
	logic [31:0]   value_pool[POOL_N];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_id     = 0;
	int hold_seen;
	int hold_left;
	int n_errors    = 0;
	int quiet_cyc;

	bounded_integer_set_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// shadow table: apply one request and work out its result
	task automatic apply_set_request(input set_request_t req, output set_outcome_t res);
		int      slot;
		status_t st;
		slot = -1;
		for (int i = 0; i < member_cnt; i++)
			if (slot < 0 && set_members[i] == req.value)
				slot = i;
		case (req.act)
			ACT_INSERT: begin
				if (member_cnt >= CAP)
					st = STS_FULL;
				else if (slot >= 0)
					st = STS_DUP;
				else begin
					set_members[member_cnt] = req.value;
					member_cnt++;
					st = STS_DONE;
				end
			end
			ACT_REMOVE: begin
				if (slot >= 0) begin
					member_cnt--;
					set_members[slot] = set_members[member_cnt];
					st = STS_DONE;
				end else
					st = STS_ABSENT;
			end
			// lookup and the spare code
			default: st = (slot >= 0) ? STS_DONE : STS_ABSENT;
		endcase
		res.found     = (slot >= 0);
		res.status    = st;
		res.count     = member_cnt[COUNT_W-1:0];
		res.empty_res = (member_cnt == 0);
	endtask

	// request driver; predicts on every accepted request
	always @(posedge clk or negedge arst_n) begin
		set_outcome_t res;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				apply_set_request(set_request_t'(s_tdata[ACTION_W+VALUE_W-1:0]), res);
				outcome_q.insert(outcome_q.size(), res);
			end
			if (request_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata  <= {{(S_TDATA_W-ACTION_W-VALUE_W){1'b0}}, request_q.pop_front()};
			end else
				s_tvalid <= 1'b0;
		end
	end

	// result side ready, with random stalls and the long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_seen <= 0;
			hold_left <= 0;
		end else if (hold_seen != hold_id) begin
			hold_seen <= hold_id;
			hold_left <= HOLD_LEN;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// result monitor
	always @(posedge clk) begin
		set_outcome_t got, exp;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[11:0];
			if (outcome_q.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("%0t: result with no request pending: %h", $realtime, m_tdata);
			end else begin
				exp = outcome_q.pop_front();
				if (got.found !== exp.found || got.status !== exp.status ||
				    got.count !== exp.count || got.empty_res !== exp.empty_res) begin
					n_errors++;
					if (n_errors <= 10)
						$display({"%0t: mismatch exp found=%0b status=%0d count=%0d ",
							"empty=%0b, got found=%0b status=%0d count=%0d empty=%0b"},
							$realtime, exp.found, exp.status, exp.count, exp.empty_res,
							got.found, got.status, got.count, got.empty_res);
				end
			end
		end
	end

	// watchdog on cycles with no request or result moving
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quiet_cyc <= 0;
		else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cyc <= 0;
		else if (quiet_cyc >= WD_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else
			quiet_cyc <= quiet_cyc + 1;
	end

	task automatic push_req(input action_t act, input logic [31:0] v);
		set_request_t req;
		req.act   = act;
		req.value = v;
		request_q.insert(request_q.size(), req);
	endtask

	// random requests, mostly on pooled values so hits are common
	task automatic queue_random(input int n, input int w_ins, input int w_rem);
		action_t     act;
		logic [31:0] v;
		int          r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < w_ins)
				act = ACT_INSERT;
			else if (r < w_ins + w_rem)
				act = ACT_REMOVE;
			else
				act = $urandom_range(1) ? ACT_LOOKUP : ACT_SPARE;
			v = ($urandom_range(99) < 85) ? value_pool[$urandom_range(POOL_N-1)] : $urandom;
			push_req(act, v);
		end
	endtask

	task automatic wait_sent;
		while (request_q.size() != 0 || s_tvalid)
			@(negedge clk);
	endtask

	task automatic wait_drained;
		wait_sent();
		while (outcome_q.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		for (int i = 0; i < POOL_N; i++)
			value_pool[i] = $urandom;
		value_pool[0] = 32'h0000_0000;
		value_pool[1] = 32'hFFFF_FFFF;
		value_pool[2] = 32'h8000_0000;
		value_pool[3] = 32'h7FFF_FFFF;
		value_pool[4] = 32'h0000_0001;
		member_cnt = 0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, extremes, duplicates, swap-on-remove
		push_req(ACT_LOOKUP, 32'h0000_0000);
		push_req(ACT_REMOVE, 32'hFFFF_FFFF);
		push_req(ACT_SPARE,  32'h8000_0000);
		push_req(ACT_INSERT, 32'h8000_0000);
		push_req(ACT_INSERT, 32'h7FFF_FFFF);
		push_req(ACT_INSERT, 32'h0000_0000);
		push_req(ACT_INSERT, 32'hFFFF_FFFF);
		push_req(ACT_INSERT, 32'h7FFF_FFFF);
		push_req(ACT_LOOKUP, 32'h8000_0000);
		push_req(ACT_SPARE,  32'h7FFF_FFFF);
		push_req(ACT_SPARE,  32'h0000_0005);
		push_req(ACT_REMOVE, 32'h0000_0000);
		push_req(ACT_LOOKUP, 32'hFFFF_FFFF);
		push_req(ACT_LOOKUP, 32'h0000_0000);
		push_req(ACT_REMOVE, 32'h7FFF_FFFF);
		push_req(ACT_REMOVE, 32'h7FFF_FFFF);
		push_req(ACT_REMOVE, 32'h8000_0000);
		push_req(ACT_REMOVE, 32'hFFFF_FFFF);
		push_req(ACT_LOOKUP, 32'hFFFF_FFFF);
		push_req(ACT_INSERT, 32'h5555_AAAA);
		push_req(ACT_REMOVE, 32'h5555_AAAA);
		wait_sent();

		// fill the table well past capacity, no idling; long result stall early on
		queue_random(300, 70, 15);
		hold_id = hold_id + 1;
		wait_sent();

		// mixed traffic, sender idling; then hold until every result is back
		tx_idle_pct = 56;
		queue_random(300, 35, 35);
		wait_drained();

		// drain toward empty, receiver stalling
		tx_idle_pct = 0;
		rx_idle_pct = 56;
		queue_random(300, 15, 70);
		wait_sent();

		// balanced traffic, both sides idling
		tx_idle_pct = 15;
		rx_idle_pct = 15;
		queue_random(400, 40, 40);
		wait_drained();

		repeat (TAIL_CYC) @(posedge clk);
		if (n_errors == 0 && outcome_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
